@@ rtl/sparse_threshold_matrix_multiply_core_macros.svh @@
// Assertion macros shared by the RTL of the sparse threshold matrix multiply core.
`ifndef SPARSE_THRESHOLD_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define SPARSE_THRESHOLD_MATRIX_MULTIPLY_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define STMM_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define STMM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/stmm_pkg.sv @@
`default_nettype none

package stmm_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 32;
  localparam int THRESH_W = 31;

  // Defaults for the top-level parameters.
  localparam int MATRIX_SIZE_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Threshold after reset: only an exact zero is pruned.
  localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd1;

  // Accumulator bounds and the signed 32-bit output range.
  localparam logic signed [64:0] ACC_LIMIT_POS = 65'sd4611686018427387904;
  localparam logic signed [64:0] ACC_LIMIT_NEG = -65'sd4611686018427387904;
  localparam logic signed [63:0] SUM_MAX       = 64'sd2147483647;
  localparam logic signed [63:0] SUM_MIN       = -64'sd2147483648;
  localparam logic [VALUE_W-1:0] OUT_MAX       = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] OUT_MIN       = 32'h8000_0000;

  // Request kinds on the input channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } stmm_kind_e;

  // Classified operations held in the queue.
  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_COMPUTE,
    OP_ZERO
  } stmm_op_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } stmm_state_e;

  // One queued operation.
  typedef struct packed {
    stmm_op_e             op;
    logic                 keep;
    logic [INDEX_W-1:0]   row;
    logic [INDEX_W-1:0]   col;
    logic [VALUE_W-1:0]   value;
  } stmm_entry_t;

  // Queue fill status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } stmm_qstat_t;

endpackage

`default_nettype wire

@@ rtl/stmm_in_if.sv @@
`default_nettype none

interface stmm_in_if import stmm_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic [INDEX_W-1:0]         row_index;
  logic [INDEX_W-1:0]         col_index;
  logic signed [VALUE_W-1:0]  element_value;

  modport source (
    output valid, kind, row_index, col_index, element_value,
    input  ready
  );

  modport sink (
    input  valid, kind, row_index, col_index, element_value,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/stmm_out_if.sv @@
`default_nettype none

interface stmm_out_if import stmm_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  product_value;
  logic                       saturated;
  logic [INDEX_W-1:0]         out_row;
  logic [INDEX_W-1:0]         out_col;

  modport source (
    output valid, product_value, saturated, out_row, out_col,
    input  ready
  );

  modport sink (
    input  valid, product_value, saturated, out_row, out_col,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/stmm_front.sv @@
`default_nettype none

module stmm_front import stmm_pkg::*; #(
  parameter int MATRIX_SIZE = MATRIX_SIZE_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [THRESH_W-1:0]  cfg_wdata_i,
  stmm_in_if.sink                   req_i,
  input  wire stmm_qstat_t          q_stat_i,
  output logic                      push_o,
  output stmm_entry_t               push_entry_o
);

  logic [THRESH_W-1:0] thr_q;
  logic [VALUE_W-1:0]  mag;
  logic                keep;
  logic                in_range;
  logic                accept;

  // Prune threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // A transaction is taken whenever the queue has room.
  assign req_i.ready = !q_stat_i.full;
  assign accept      = req_i.valid && req_i.ready;

  // Magnitude test; the most negative value yields 2^31 and is always kept.
  always_comb begin
    mag = req_i.element_value[VALUE_W-1] ? VALUE_W'(~req_i.element_value + 1'b1)
                                         : VALUE_W'(req_i.element_value);
    keep     = (mag >= {1'b0, thr_q});
    in_range = (32'(req_i.row_index) < MATRIX_SIZE) &&
               (32'(req_i.col_index) < MATRIX_SIZE);
  end

  // Classify the transaction into a queue operation.
  always_comb begin
    push_entry_o.keep  = keep;
    push_entry_o.row   = req_i.row_index;
    push_entry_o.col   = req_i.col_index;
    push_entry_o.value = req_i.element_value;
    push_entry_o.op    = OP_ZERO;
    push_o             = 1'b0;
    case (stmm_kind_e'(req_i.kind))
      KIND_LOAD_A: begin
        push_entry_o.op = OP_LOAD_A;
        push_o          = accept && in_range;
      end
      KIND_LOAD_B: begin
        push_entry_o.op = OP_LOAD_B;
        push_o          = accept && in_range;
      end
      KIND_COMPUTE: begin
        // An out-of-range request still returns a zero result.
        push_entry_o.op = in_range ? OP_COMPUTE : OP_ZERO;
        push_o          = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/stmm_queue.sv @@
`default_nettype none

module stmm_queue import stmm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire stmm_entry_t  push_entry_i,
  input  wire logic         pop_i,
  output stmm_entry_t       head_o,
  output stmm_qstat_t       stat_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  stmm_entry_t      entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign head_o       = entries_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

@@ rtl/stmm_back.sv @@
`default_nettype none

module stmm_back import stmm_pkg::*; #(
  parameter int MATRIX_SIZE   = MATRIX_SIZE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire stmm_entry_t  head_i,
  input  wire stmm_qstat_t  q_stat_i,
  output logic              pop_o,
  stmm_out_if.source        rsp_o
);

  localparam int IDX_W  = $clog2(MATRIX_SIZE);
  localparam int ADDR_W = $clog2(MATRIX_SIZE * MATRIX_SIZE);
  localparam int DEPTH  = MATRIX_SIZE * MATRIX_SIZE;
  localparam logic [IDX_W-1:0]  K_LAST = IDX_W'(MATRIX_SIZE - 1);
  localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MATRIX_SIZE);

  stmm_state_e state_q, state_d;

  // Element stores and presence bits; B presence is kept per column.
  logic [VALUE_W-1:0]     a_mem_q [DEPTH];
  logic [VALUE_W-1:0]     b_mem_q [DEPTH];
  logic [MATRIX_SIZE-1:0] a_present_q [MATRIX_SIZE];
  logic [MATRIX_SIZE-1:0] b_present_q [MATRIX_SIZE];

  logic [INDEX_W-1:0]      row_q, col_q;
  logic [MATRIX_SIZE-1:0]  shared_q;
  logic [IDX_W-1:0]        k_q;
  logic                    drain_q;
  logic                    rd_valid_q, prod_valid_q;
  logic signed [VALUE_W-1:0] a_rd_q, b_rd_q;
  logic signed [63:0]      prod_q;
  logic signed [63:0]      acc_q, acc_d;
  logic signed [63:0]      prod_shift;
  logic signed [64:0]      sum_ext;

  logic                    out_valid_q;
  logic [VALUE_W-1:0]      out_value_q, out_value_d;
  logic                    out_sat_q, out_sat_d;
  logic [INDEX_W-1:0]      out_row_q, out_col_q;

  logic                    wr_a, wr_b, ld_a, ld_b;
  logic                    start, zero, rd_en, out_load;
  logic [IDX_W-1:0]        head_row, head_col, row_idx, col_idx;
  logic [ADDR_W-1:0]       waddr, a_raddr, b_raddr;

  assign head_row = IDX_W'(head_i.row);
  assign head_col = IDX_W'(head_i.col);
  assign row_idx  = IDX_W'(row_q);
  assign col_idx  = IDX_W'(col_q);

  // Both stores are addressed row-major.
  assign waddr   = ADDR_W'(head_row) * STRIDE + ADDR_W'(head_col);
  assign a_raddr = ADDR_W'(row_idx) * STRIDE + ADDR_W'(k_q);
  assign b_raddr = ADDR_W'(k_q) * STRIDE + ADDR_W'(col_idx);

  // Sequencer outputs.
  always_comb begin
    pop_o    = (state_q == ST_IDLE) && !q_stat_i.empty;
    ld_a     = pop_o && (head_i.op == OP_LOAD_A);
    ld_b     = pop_o && (head_i.op == OP_LOAD_B);
    wr_a     = ld_a && head_i.keep;
    wr_b     = ld_b && head_i.keep;
    start    = pop_o && (head_i.op == OP_COMPUTE);
    zero     = pop_o && (head_i.op == OP_ZERO);
    rd_en    = (state_q == ST_ISSUE) && shared_q[k_q];
    out_load = (state_q == ST_FINISH) && (!out_valid_q || rsp_o.ready);
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_ISSUE;
        end else if (zero) begin
          state_d = ST_FINISH;
        end
      end
      ST_ISSUE: begin
        if (k_q == K_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers of the sequencer and the multiply pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
      drain_q      <= 1'b0;
      k_q          <= '0;
    end else begin
      state_q      <= state_d;
      rd_valid_q   <= rd_en;
      prod_valid_q <= rd_valid_q;
      if (start) begin
        k_q <= '0;
      end else if (state_q == ST_ISSUE) begin
        k_q <= k_q + 1'b1;
      end
      drain_q <= (state_q == ST_DRAIN);
    end
  end

  // Presence bits: a pruned load clears, a kept load sets.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MATRIX_SIZE; i++) begin
        a_present_q[i] <= '0;
        b_present_q[i] <= '0;
      end
    end else begin
      if (ld_a) begin
        a_present_q[head_row][head_col] <= head_i.keep;
      end
      if (ld_b) begin
        b_present_q[head_col][head_row] <= head_i.keep;
      end
    end
  end

  // Store writes.
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      a_mem_q[waddr] <= head_i.value;
    end
    if (wr_b) begin
      b_mem_q[waddr] <= head_i.value;
    end
  end

  // Registered store reads, one shared key per cycle.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      a_rd_q <= a_mem_q[a_raddr];
      b_rd_q <= b_mem_q[b_raddr];
    end
  end

  // Floor-shifted product added with clamping to plus or minus 2^62.
  always_comb begin
    prod_shift = prod_q >>> FRACTION_BITS;
    sum_ext    = 65'(acc_q) + 65'(prod_shift);
    if (sum_ext > ACC_LIMIT_POS) begin
      acc_d = ACC_LIMIT_POS[63:0];
    end else if (sum_ext < ACC_LIMIT_NEG) begin
      acc_d = ACC_LIMIT_NEG[63:0];
    end else begin
      acc_d = sum_ext[63:0];
    end
  end

  // Request capture, product and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (start || zero) begin
      row_q    <= head_i.row;
      col_q    <= head_i.col;
      shared_q <= a_present_q[head_row] & b_present_q[head_col];
      acc_q    <= '0;
    end else if (prod_valid_q) begin
      acc_q <= acc_d;
    end
    if (rd_valid_q) begin
      prod_q <= a_rd_q * b_rd_q;
    end
  end

  // Final saturation to the signed 32-bit range.
  always_comb begin
    if (acc_q > SUM_MAX) begin
      out_value_d = OUT_MAX;
      out_sat_d   = 1'b1;
    end else if (acc_q < SUM_MIN) begin
      out_value_d = OUT_MIN;
      out_sat_d   = 1'b1;
    end else begin
      out_value_d = acc_q[VALUE_W-1:0];
      out_sat_d   = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= out_value_d;
      out_sat_q   <= out_sat_d;
      out_row_q   <= row_q;
      out_col_q   <= col_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.product_value = out_value_q;
  assign rsp_o.saturated     = out_sat_q;
  assign rsp_o.out_row       = out_row_q;
  assign rsp_o.out_col       = out_col_q;

endmodule

`default_nettype wire

@@ rtl/sparse_threshold_matrix_multiply_core.sv @@
// Sparse thresholded matrix multiply, one result element per compute request.
// The request channel carries loads of A and B elements and compute requests
// for one (row, column) of A times B. Loads below the prune threshold mark the
// element absent. Each compute request returns one transaction on the response
// channel with the saturated Q16.16 dot product, a saturation flag and the
// echoed indexes; loads and unused kinds return nothing.
// The front end classifies requests into a four-entry queue and accepts one
// transaction per cycle while the queue has room. The back end takes one queued
// operation at a time: a load is written as it is dequeued, while a compute steps
// one key per cycle through the single read port of each element store, then
// through the product and accumulator registers to the response register. A
// response waiting on a stalled receiver holds the back end in its final state,
// while the front keeps filling the queue.
// Reset clears all presence bits, sets the threshold to 1 and empties the queue;
// the element stores are not cleared. The user must write the threshold through
// cfg_we_i and cfg_wdata_i only while the core is idle; the core does not check.
`default_nettype none

`include "sparse_threshold_matrix_multiply_core_macros.svh"

module sparse_threshold_matrix_multiply_core import stmm_pkg::*; #(
  parameter int MATRIX_SIZE   = MATRIX_SIZE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [THRESH_W-1:0]  cfg_wdata_i,
  stmm_in_if.sink                   req_i,
  stmm_out_if.source                rsp_o
);

  logic        q_push;
  logic        q_pop;
  stmm_entry_t q_push_entry;
  stmm_entry_t q_head;
  stmm_qstat_t q_stat;

  // Request classification and threshold register.
  stmm_front #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req_i),
    .q_stat_i     (q_stat),
    .push_o       (q_push),
    .push_entry_o (q_push_entry)
  );

  // Command queue between the two halves.
  stmm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .stat_o       (q_stat)
  );

  // Element stores and multiply-accumulate engine.
  stmm_back #(
    .MATRIX_SIZE   (MATRIX_SIZE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (q_head),
    .q_stat_i (q_stat),
    .pop_o    (q_pop),
    .rsp_o    (rsp_o)
  );

  // The queue is never written when full nor read when empty.
  `STMM_ASSERT_IMPLY(a_queue_no_overflow, clk_i, rst_ni, q_push, !q_stat.full, "queue overflow")
  `STMM_ASSERT_IMPLY(a_queue_no_underflow, clk_i, rst_ni, q_pop, !q_stat.empty, "queue underflow")
  // A saturated response carries one of the two range limits.
  `STMM_ASSERT_IMPLY(a_sat_at_limit, clk_i, rst_ni, rsp_o.valid && rsp_o.saturated, (rsp_o.product_value == OUT_MAX) || (rsp_o.product_value == OUT_MIN), "saturated value not at limit")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import stmm_pkg::*;

  localparam int N = MATRIX_SIZE_DEF;
  localparam int FRAC = FRACTION_BITS_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam longint ACC_BOUND = 64'sh4000_0000_0000_0000;
  // Worst drain after the last response: a full queue of loads behind a compute.
  localparam int SETTLE_CYCLES = (QUEUE_DEPTH + 2) * (N + 4);
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int HOLD_OFF_AT = 400;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DIRECTED_ROWS = 24;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] row;
    logic [INDEX_W-1:0] col;
    logic [VALUE_W-1:0] value;
  } mm_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] product;
    logic               sat;
    logic [INDEX_W-1:0] row;
    logic [INDEX_W-1:0] col;
  } dot_result_t;

  // One directed row; a typed expectation overrides the computed one.
  typedef struct packed {
    mm_req_t            req;
    logic               typed;
    logic [VALUE_W-1:0] exp_value;
    logic               exp_sat;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [THRESH_W-1:0] cfg_wdata_i;

  stmm_in_if  req_if ();
  stmm_out_if rsp_if ();

  sparse_threshold_matrix_multiply_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Shadow copy of the element stores, presence maps and threshold.
  logic [VALUE_W-1:0]  a_store [N][N];
  logic [VALUE_W-1:0]  b_store [N][N];
  logic [N-1:0]        a_present [N];
  logic [N-1:0]        b_present [N];
  logic [THRESH_W-1:0] thresh_model;

  dot_result_t expected_products [$];

  int error_count = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int requests_accepted = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int thresholds_used = 1;
  bit hold_off_done = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Nothing is present after reset.
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'hA5A5_5A5A}, 1'b1, 32'h0000_0000, 1'b0},
    '{'{KIND_COMPUTE, 4'd15, 4'd15, 32'h5A5A_A5A5}, 1'b1, 32'h0000_0000, 1'b0},
    // A zero is pruned at the reset threshold, so the intersection stays empty.
    '{'{KIND_LOAD_A,  4'd0,  4'd0,  32'h0000_0000}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_LOAD_B,  4'd0,  4'd0,  32'h7FFF_FFFF}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'h0000_0000}, 1'b1, 32'h0000_0000, 1'b0},
    // Largest positive squared saturates high.
    '{'{KIND_LOAD_A,  4'd0,  4'd0,  32'h7FFF_FFFF}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'hFFFF_FFFF}, 1'b1, 32'h7FFF_FFFF, 1'b1},
    // Most negative value is kept and cancels most of the first product.
    '{'{KIND_LOAD_A,  4'd0,  4'd1,  32'h8000_0000}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_LOAD_B,  4'd1,  4'd0,  32'h7FFF_FFFF}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'h0000_0000}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_LOAD_B,  4'd1,  4'd0,  32'h8000_0000}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'h0000_0000}, 1'b0, 32'h0, 1'b0},
    // Two large negative products saturate low.
    '{'{KIND_LOAD_A,  4'd0,  4'd0,  32'h8000_0000}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_LOAD_B,  4'd1,  4'd0,  32'h7FFF_FFFF}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'h0000_0000}, 1'b1, 32'h8000_0000, 1'b1},
    // One times minus one at the far corner.
    '{'{KIND_LOAD_A,  4'd15, 4'd15, 32'h0001_0000}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_LOAD_B,  4'd15, 4'd15, 32'hFFFF_0000}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_COMPUTE, 4'd15, 4'd15, 32'h0000_0000}, 1'b1, 32'hFFFF_0000, 1'b0},
    // The unused kind must be dropped without a response.
    '{'{KIND_UNUSED,  4'd15, 4'd15, 32'hFFFF_FFFF}, 1'b0, 32'h0, 1'b0},
    // A pruned load clears an element that was present.
    '{'{KIND_LOAD_A,  4'd15, 4'd15, 32'h0000_0000}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_COMPUTE, 4'd15, 4'd15, 32'h0000_0000}, 1'b1, 32'h0000_0000, 1'b0},
    // Smallest magnitudes: the negative product floors to minus one LSB.
    '{'{KIND_LOAD_A,  4'd3,  4'd7,  32'hFFFF_FFFF}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_LOAD_B,  4'd7,  4'd3,  32'h0000_0001}, 1'b0, 32'h0, 1'b0},
    '{'{KIND_COMPUTE, 4'd3,  4'd3,  32'h0000_0000}, 1'b0, 32'h0, 1'b0}
  };

  // Clock.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Applies one accepted request to the shadow state. Returns 1 with the dot
  // product when the request is a compute.
  function automatic bit shadow_apply(input mm_req_t r, output dot_result_t res);
    longint mag;
    longint acc;
    longint prod;
    logic [N-1:0] shared;
    bit pruned;
    res = '0;
    shadow_apply = 1'b0;
    mag = longint'($signed(r.value));
    if (mag < 0) mag = -mag;
    pruned = (mag < longint'(thresh_model));
    case (r.kind)
      KIND_LOAD_A: begin
        if (pruned) begin
          a_present[r.row][r.col] = 1'b0;
        end else begin
          a_store[r.row][r.col] = r.value;
          a_present[r.row][r.col] = 1'b1;
        end
      end
      KIND_LOAD_B: begin
        // B[row][col] is key "row" of column "col".
        if (pruned) begin
          b_present[r.col][r.row] = 1'b0;
        end else begin
          b_store[r.row][r.col] = r.value;
          b_present[r.col][r.row] = 1'b1;
        end
      end
      KIND_COMPUTE: begin
        acc = 0;
        shared = a_present[r.row] & b_present[r.col];
        for (int k = 0; k < N; k++) begin
          if (shared[k]) begin
            prod = longint'($signed(a_store[r.row][k])) *
                   longint'($signed(b_store[k][r.col]));
            acc += prod >>> FRAC;
            if (acc > ACC_BOUND) acc = ACC_BOUND;
            if (acc < -ACC_BOUND) acc = -ACC_BOUND;
          end
        end
        if (acc > SUM_MAX) begin
          res.product = OUT_MAX;
          res.sat = 1'b1;
        end else if (acc < SUM_MIN) begin
          res.product = OUT_MIN;
          res.sat = 1'b1;
        end else begin
          res.product = acc[VALUE_W-1:0];
        end
        res.row = r.row;
        res.col = r.col;
        shadow_apply = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // A value within one LSB of the current threshold, either sign.
  function automatic logic [VALUE_W-1:0] near_threshold();
    longint mag;
    longint v;
    mag = longint'(thresh_model) + longint'($urandom_range(2, 0)) - 1;
    if (mag < 0) mag = 0;
    v = ($urandom_range(1, 0) != 0) ? -mag : mag;
    if (v > SUM_MAX) v = -v;
    return v[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(9, 0))
      0: v = '0;
      1: begin
        case ($urandom_range(4, 0))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h8000_0001;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      2, 3: v = near_threshold();
      4, 5, 6: v = $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic mm_req_t random_request();
    mm_req_t r;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 36) r.kind = KIND_LOAD_A;
    else if (pick < 72) r.kind = KIND_LOAD_B;
    else if (pick < 95) r.kind = KIND_COMPUTE;
    else r.kind = KIND_UNUSED;
    // A quarter of the requests crowd into a corner so intersections get dense.
    if ($urandom_range(3, 0) == 0) begin
      r.row = INDEX_W'($urandom_range(3, 0));
      r.col = INDEX_W'($urandom_range(3, 0));
    end else begin
      r.row = INDEX_W'($urandom_range(N - 1, 0));
      r.col = INDEX_W'($urandom_range(N - 1, 0));
    end
    r.value = pick_value();
    return r;
  endfunction

  // Offers one request and returns at the edge where it is accepted. Between
  // bursts the valid line drops for a random gap.
  task automatic issue_request(input mm_req_t r);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
    end
    req_if.valid         <= 1'b1;
    req_if.kind          <= r.kind;
    req_if.row_index     <= r.row;
    req_if.col_index     <= r.col;
    req_if.element_value <= r.value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    burst_left--;
    requests_accepted++;
  endtask

  // Writes the threshold once the core has drained.
  task automatic set_threshold(input logic [THRESH_W-1:0] t);
    req_if.valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= t;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thresh_model = t;
    burst_left = 0;
    thresholds_used++;
  endtask

  // Request stream: directed table, then random phases at several thresholds.
  initial begin : stimulus
    mm_req_t r;
    dot_result_t res;
    bit has_res;
    logic [THRESH_W-1:0] phase_thresh [PHASES];
    req_if.valid         = 1'b0;
    req_if.kind          = KIND_LOAD_A;
    req_if.row_index     = '0;
    req_if.col_index     = '0;
    req_if.element_value = '0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    rst_ni               = 1'b0;
    thresh_model         = THRESH_RESET;
    for (int i = 0; i < N; i++) begin
      a_present[i] = '0;
      b_present[i] = '0;
    end
    phase_thresh[0] = '0;
    phase_thresh[1] = 31'h7FFF_FFFF;
    phase_thresh[2] = 31'h0001_0000;
    phase_thresh[3] = THRESH_W'($urandom_range(32'h7FFF_FFFF, 0));
    phase_thresh[4] = THRESH_RESET;
    phase_thresh[5] = THRESH_W'($urandom_range(32'h0010_0000, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].req);
      has_res = shadow_apply(directed_rows[i].req, res);
      if (directed_rows[i].typed) begin
        res.product = directed_rows[i].exp_value;
        res.sat = directed_rows[i].exp_sat;
      end
      if (has_res) expected_products.push_back(res);
    end

    for (int p = 0; p < PHASES; p++) begin
      set_threshold(phase_thresh[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = random_request();
        issue_request(r);
        if (shadow_apply(r, res)) expected_products.push_back(res);
      end
    end
    req_if.valid <= 1'b0;

    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests over %0d threshold settings; checked %0d products, %0d saturated.",
             requests_accepted, thresholds_used, results_seen, sat_seen);
    $display("Response side held off for %0d cycles once to back up the request queue.",
             HOLD_OFF_CYCLES);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Response ready: changing stall patterns, plus one long hold-off mid-run.
  initial begin : rsp_backpressure
    int mode;
    int mode_left;
    int tick;
    int held;
    mode = 0;
    mode_left = 0;
    tick = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_off_done && requests_accepted >= HOLD_OFF_AT) begin
        hold_off_done = 1'b1;
        rsp_if.ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(3, 0);
        mode_left = $urandom_range(200, 32);
      end
      mode_left--;
      tick++;
      case (mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(1, 0) != 0);
        2: rsp_if.ready <= (tick % 4 == 0);
        default: rsp_if.ready <= ($urandom_range(9, 0) != 0);
      endcase
    end
  end

  // Compare each response transaction with the oldest expected product.
  always @(posedge clk_i) begin : product_checker
    dot_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_products.size() == 0) begin
        $error("unexpected response: row %0d col %0d product %h",
               rsp_if.out_row, rsp_if.out_col, rsp_if.product_value);
        error_count++;
      end else begin
        want = expected_products.pop_front();
        results_seen++;
        if (rsp_if.saturated) sat_seen++;
        if (rsp_if.product_value !== want.product) begin
          $error("product_value: expected %h, got %h", want.product, rsp_if.product_value);
          error_count++;
        end
        if (rsp_if.saturated !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, rsp_if.saturated);
          error_count++;
        end
        if (rsp_if.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, rsp_if.out_row);
          error_count++;
        end
        if (rsp_if.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, rsp_if.out_col);
          error_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d products outstanding.",
             cycle_count, expected_products.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/stmm_pkg.sv
rtl/stmm_in_if.sv
rtl/stmm_out_if.sv
rtl/stmm_front.sv
rtl/stmm_queue.sv
rtl/stmm_back.sv
rtl/sparse_threshold_matrix_multiply_core.sv
tb/tb.sv
